// ===== src/scfe_pkg.sv =====
// Shared types and constants for the serial command frame encoder.
`default_nettype none
package scfe_pkg;

    localparam logic       CMD_START     = 1'b0;
    localparam logic       CMD_DATA      = 1'b1;
    localparam logic [7:0] LEN_LIMIT     = 8'd6;
    localparam logic [2:0] LONG_LEN_CODE = 3'h7;
    localparam int         BURST_MAX     = 3;

    typedef logic [7:0] byte_t;

    typedef struct packed {
        byte_t [BURST_MAX-1:0] data;
        logic  [1:0]           count;
        logic                  close;
    } burst_t;

endpackage
`default_nettype wire

// ===== src/scfe_frame_builder.sv =====
// Frame state and per-transfer byte burst generation.
`default_nettype none
module scfe_frame_builder (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           fire,
    input  wire logic           command,
    input  wire logic [4:0]     device_address,
    input  wire logic [7:0]     command_code,
    input  wire logic [7:0]     payload_length,
    input  wire logic [7:0]     payload_byte,
    output scfe_pkg::burst_t    burst
);
    import scfe_pkg::*;

    byte_t      xor_reg, xor_next;
    logic [7:0] remain_reg, remain_next;
    logic       open_reg, open_next;

    byte_t header;
    byte_t xor_start;
    byte_t xor_data;
    logic  is_long;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            xor_reg    <= '0;
            remain_reg <= '0;
            open_reg   <= 1'b0;
        end else if (fire) begin
            xor_reg    <= xor_next;
            remain_reg <= remain_next;
            open_reg   <= open_next;
        end
    end

    always_comb begin
        is_long     = (payload_length > LEN_LIMIT);
        header      = {device_address, is_long ? LONG_LEN_CODE : payload_length[2:0]};
        xor_start   = header ^ command_code;
        xor_data    = xor_reg ^ payload_byte;
        burst       = '0;
        xor_next    = xor_reg;
        remain_next = remain_reg;
        open_next   = open_reg;
        case (command)
            CMD_START: begin
                burst.data[0] = header;
                burst.data[1] = command_code;
                remain_next   = payload_length;
                if (is_long) begin
                    burst.data[2] = payload_length;
                    burst.count   = 2'd3;
                    xor_next      = xor_start ^ payload_length;
                    open_next     = 1'b1;
                end else if (payload_length == 8'd0) begin
                    burst.data[2] = xor_start;
                    burst.count   = 2'd3;
                    burst.close   = 1'b1;
                    xor_next      = '0;
                    open_next     = 1'b0;
                end else begin
                    burst.count   = 2'd2;
                    xor_next      = xor_start;
                    open_next     = 1'b1;
                end
            end
            default: begin
                if (!open_reg || remain_reg == 8'd0) begin
                    open_next   = 1'b0;
                    remain_next = '0;
                end else begin
                    burst.data[0] = payload_byte;
                    remain_next   = remain_reg - 8'd1;
                    if (remain_reg == 8'd1) begin
                        burst.data[1] = xor_data;
                        burst.count   = 2'd2;
                        burst.close   = 1'b1;
                        xor_next      = '0;
                        open_next     = 1'b0;
                    end else begin
                        burst.count   = 2'd1;
                        xor_next      = xor_data;
                    end
                end
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== src/scfe_byte_queue.sv =====
// Result register holding one burst and shifting it out one byte per transfer.
`default_nettype none
module scfe_byte_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           load,
    input  wire scfe_pkg::burst_t burst,
    output logic                can_load,
    output logic                m_valid,
    input  wire logic           m_ready,
    output logic [7:0]          m_tx_byte,
    output logic                m_last_of_frame
);
    import scfe_pkg::*;

    byte_t [BURST_MAX-1:0] data_reg, data_next;
    logic  [1:0]           count_reg, count_next;
    logic                  close_reg, close_next;
    logic                  m_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            close_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            close_reg <= close_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    always_comb begin
        m_valid         = (count_reg != 2'd0);
        m_tx_byte       = data_reg[0];
        m_last_of_frame = close_reg && (count_reg == 2'd1);
        m_fire          = m_valid && m_ready;
        can_load        = (count_reg == 2'd0) || (count_reg == 2'd1 && m_ready);
        data_next       = data_reg;
        count_next      = count_reg;
        close_next      = close_reg;
        if (load) begin
            data_next  = burst.data;
            count_next = burst.count;
            close_next = burst.close;
        end else if (m_fire) begin
            data_next  = {8'h00, data_reg[BURST_MAX-1:1]};
            count_next = count_reg - 2'd1;
        end
    end

endmodule
`default_nettype wire

// ===== src/serial_command_frame_encoder.sv =====
// Top level: serial bus command frame encoder.
// The first byte of an item appears in the cycle after its transfer.
// Bytes per item: start 2-3, payload 1 (2 when closing, none if stray);
// the byte queue takes a new item when empty or as its last byte goes.
// Reset: synchronous active-low aresetn clears frame state and the queue.
`default_nettype none
module serial_command_frame_encoder (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic       s_command,
    input  wire logic [4:0] s_device_address,
    input  wire logic [7:0] s_command_code,
    input  wire logic [7:0] s_payload_length,
    input  wire logic [7:0] s_payload_byte,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_tx_byte,
    output logic            m_last_of_frame
);
    import scfe_pkg::*;

    burst_t burst;
    logic   s_fire;
    logic   can_load;

    assign s_ready = can_load;
    assign s_fire  = s_valid && can_load;

    scfe_frame_builder u_builder (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .fire           (s_fire),
        .command        (s_command),
        .device_address (s_device_address),
        .command_code   (s_command_code),
        .payload_length (s_payload_length),
        .payload_byte   (s_payload_byte),
        .burst          (burst)
    );

    scfe_byte_queue u_queue (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .load            (s_fire),
        .burst           (burst),
        .can_load        (can_load),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_tx_byte       (m_tx_byte),
        .m_last_of_frame (m_last_of_frame)
    );

endmodule
`default_nettype wire

// ===== tb/sv/tb_serial_command_frame_encoder.sv =====
// Testbench for the serial command frame encoder: random and directed frames, byte-level check.
`timescale 1ns / 1ps
module tb_serial_command_frame_encoder;
    import scfe_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 300;

    typedef struct packed {
        logic       cmd;
        logic [4:0] addr;
        logic [7:0] code;
        logic [7:0] len;
        logic [7:0] data;
    } frame_item_t;

    typedef struct packed {
        logic [7:0] tx;
        logic       last;
    } frame_byte_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic       s_command = 1'b0;
    logic [4:0] s_device_address = '0;
    logic [7:0] s_command_code = '0;
    logic [7:0] s_payload_length = '0;
    logic [7:0] s_payload_byte = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_tx_byte;
    logic       m_last_of_frame;

    frame_item_t cmd_queue[$];
    frame_byte_t frame_bytes_due[$];

    // predictor state
    logic [7:0] frame_xor = '0;
    logic [7:0] payload_left = '0;
    logic       frame_active = 1'b0;

    int send_idle_pct = 30;
    int recv_idle_pct = 73;
    int hold_left = 0;
    int quiet_cycles = 0;
    int errors = 0;
    int items_in = 0;
    int items_dropped = 0;
    int bytes_out = 0;
    int frames_closed = 0;
    int frames_abandoned = 0;

    serial_command_frame_encoder dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_device_address (s_device_address),
        .s_command_code   (s_command_code),
        .s_payload_length (s_payload_length),
        .s_payload_byte   (s_payload_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_tx_byte        (m_tx_byte),
        .m_last_of_frame  (m_last_of_frame)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    task automatic push_frame_byte(input logic [7:0] b);
        frame_xor = frame_xor ^ b;
        frame_bytes_due.push_back('{tx: b, last: 1'b0});
    endtask

    task automatic close_frame();
        frame_bytes_due.push_back('{tx: frame_xor, last: 1'b1});
        frame_xor = '0;
        payload_left = '0;
        frame_active = 1'b0;
    endtask

    task automatic encode_item(input frame_item_t it);
        logic [2:0] len_field;
        if (it.cmd == CMD_START) begin
            if (frame_active) frames_abandoned++;
            len_field = (it.len > LEN_LIMIT) ? LONG_LEN_CODE : it.len[2:0];
            frame_xor = '0;
            push_frame_byte({it.addr, len_field});
            push_frame_byte(it.code);
            if (it.len > LEN_LIMIT) push_frame_byte(it.len);
            if (it.len == 8'd0) begin
                close_frame();
            end else begin
                payload_left = it.len;
                frame_active = 1'b1;
            end
        end else if (!frame_active || payload_left == 8'd0) begin
            frame_active = 1'b0;
            payload_left = '0;
            items_dropped++;
        end else begin
            push_frame_byte(it.data);
            payload_left = payload_left - 8'd1;
            if (payload_left == 8'd0) close_frame();
        end
    endtask

    // sender
    always @(posedge aclk) begin : drive_p
        frame_item_t it;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                encode_item('{cmd: s_command, addr: s_device_address, code: s_command_code,
                              len: s_payload_length, data: s_payload_byte});
                items_in++;
            end
            if (!s_valid || s_ready) begin
                if (cmd_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    it = cmd_queue.pop_front();
                    s_valid          <= 1'b1;
                    s_command        <= it.cmd;
                    s_device_address <= it.addr;
                    s_command_code   <= it.code;
                    s_payload_length <= it.len;
                    s_payload_byte   <= it.data;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver; hold_left is loaded at the falling edge for a long stall
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin : check_p
        frame_byte_t want;
        if (aresetn && m_valid && m_ready) begin
            bytes_out++;
            if (frame_bytes_due.size() == 0) begin
                $display("%0t: unexpected byte: tx_byte=%02h last_of_frame=%0b",
                         $time, m_tx_byte, m_last_of_frame);
                errors++;
            end else begin
                want = frame_bytes_due.pop_front();
                if (m_tx_byte !== want.tx) begin
                    $display("%0t: tx_byte mismatch: expected %02h, actual %02h",
                             $time, want.tx, m_tx_byte);
                    errors++;
                end
                if (m_last_of_frame !== want.last) begin
                    $display("%0t: last_of_frame mismatch: expected %0b, actual %0b",
                             $time, want.last, m_last_of_frame);
                    errors++;
                end
                if (want.last) frames_closed++;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) ||
            (cmd_queue.size() == 0 && !s_valid && frame_bytes_due.size() == 0)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d bytes outstanding",
                     $time, quiet_cycles, frame_bytes_due.size());
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic queue_item(input logic cmd, input logic [4:0] addr, input logic [7:0] code,
                              input logic [7:0] len, input logic [7:0] data);
        cmd_queue.push_back('{cmd: cmd, addr: addr, code: code, len: len, data: data});
    endtask

    task automatic queue_random(input logic cmd, input logic [7:0] len);
        queue_item(cmd, 5'($urandom), 8'($urandom), len, 8'($urandom));
    endtask

    function automatic logic [7:0] pick_length();
        int r;
        r = $urandom_range(99);
        if (r < 12) return 8'd0;
        if (r < 60) return 8'($urandom_range(6, 1));
        if (r < 75) return 8'd7;
        if (r < 93) return 8'($urandom_range(24, 8));
        if (r < 99) return 8'($urandom_range(90, 25));
        return 8'($urandom_range(255, 91));
    endfunction

    // mostly whole frames; some stray data and frames cut short by a new start
    task automatic queue_traffic(input int budget);
        int n;
        int sent;
        logic [7:0] len;
        n = 0;
        while (n < budget) begin
            if ($urandom_range(99) < 6) queue_random(CMD_DATA, 8'($urandom));
            len = pick_length();
            queue_random(CMD_START, len);
            n++;
            sent = 0;
            while (sent < len && n < budget) begin
                if ($urandom_range(99) < 3) break;
                queue_random(CMD_DATA, 8'($urandom));
                sent++;
                n++;
            end
        end
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (cmd_queue.size() > 0 || s_valid || frame_bytes_due.size() > 0);
        repeat (5) @(negedge aclk);
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        queue_item(CMD_START, 5'd31, 8'hFF, 8'd0, 8'hAA);
        queue_item(CMD_START, 5'd0, 8'h00, 8'd0, 8'h55);
        queue_item(CMD_DATA, 5'd31, 8'hFF, 8'hFF, 8'h12);
        queue_item(CMD_START, 5'd5, 8'hA5, 8'd1, 8'hFF);
        queue_item(CMD_DATA, 5'd0, 8'h00, 8'd0, 8'hFF);
        queue_item(CMD_START, 5'd10, 8'h81, 8'd6, 8'h00);
        queue_item(CMD_DATA, 5'd31, 8'hFF, 8'hFF, 8'h01);
        queue_item(CMD_DATA, 5'd0, 8'h00, 8'h00, 8'h02);
        queue_item(CMD_DATA, 5'd1, 8'h01, 8'h01, 8'h04);
        queue_item(CMD_DATA, 5'd2, 8'h02, 8'h02, 8'h08);
        queue_item(CMD_DATA, 5'd3, 8'h03, 8'h03, 8'h10);
        queue_item(CMD_DATA, 5'd4, 8'h04, 8'h04, 8'h80);
        queue_item(CMD_START, 5'd17, 8'h3C, 8'd7, 8'hFF);
        queue_item(CMD_DATA, 5'd0, 8'h00, 8'd0, 8'h7E);
        queue_item(CMD_START, 5'd31, 8'h00, 8'd255, 8'h00);
        queue_item(CMD_DATA, 5'd0, 8'h00, 8'd0, 8'hC3);
        queue_item(CMD_START, 5'd1, 8'h7F, 8'd2, 8'h00);
        queue_item(CMD_DATA, 5'd0, 8'h00, 8'd0, 8'h00);
        queue_item(CMD_DATA, 5'd0, 8'h00, 8'd0, 8'hFF);
        queue_item(CMD_DATA, 5'd21, 8'h5A, 8'd128, 8'h99);
        wait_drained();

        queue_traffic(130);
        wait_drained();

        send_idle_pct = 73;
        recv_idle_pct = 30;
        queue_traffic(130);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_traffic(130);
        @(negedge aclk);
        hold_left = LONG_HOLD;
        wait_drained();
        repeat (10) @(negedge aclk);

        $display("Run: %0d items in (%0d dropped), %0d bytes out, %0d frames closed",
                 items_in, items_dropped, bytes_out, frames_closed);
        $display("     %0d frames abandoned by a new start, %0d errors",
                 frames_abandoned, errors);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
